### rtl/cspf_pkg.sv
// shared types, constants and register map of the span fill engine
package cspf_pkg;

  localparam int WIDTH_DEF  = 320;
  localparam int HEIGHT_DEF = 240;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int COUNT_W = 17;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SPAN  = 2'd1,
    CMD_RECT  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_BRIGHTNESS  = 3'd0;
  localparam reg_idx_t REG_CLIP_LEFT   = 3'd1;
  localparam reg_idx_t REG_CLIP_TOP    = 3'd2;
  localparam reg_idx_t REG_CLIP_RIGHT  = 3'd3;
  localparam reg_idx_t REG_CLIP_BOTTOM = 3'd4;

  localparam logic [7:0] BRIGHTNESS_RST  = 8'd255;
  localparam logic [8:0] CLIP_LEFT_RST   = 9'd0;
  localparam logic [7:0] CLIP_TOP_RST    = 8'd0;
  localparam logic [8:0] CLIP_RIGHT_RST  = 9'd320;
  localparam logic [7:0] CLIP_BOTTOM_RST = 8'd240;

  typedef struct packed {
    logic [7:0] brightness;
    logic [8:0] clip_left;
    logic [7:0] clip_top;
    logic [8:0] clip_right;
    logic [7:0] clip_bottom;
  } cfg_t;

endpackage

### rtl/cspf_if.sv
// command and result channel interfaces
interface cspf_in_if;
  import cspf_pkg::*;

  logic                       valid;
  logic                       ready;
  cmd_t                       cmd;
  logic signed [COORD_W-1:0]  x;
  logic signed [COORD_W-1:0]  x_end;
  logic signed [COORD_W-1:0]  y;
  logic signed [COORD_W-1:0]  width;
  logic signed [COORD_W-1:0]  height;
  logic        [COLOR_W-1:0]  color;

  modport source (output valid, cmd, x, x_end, y, width, height, color, input ready);
  modport sink   (input valid, cmd, x, x_end, y, width, height, color, output ready);
endinterface

interface cspf_out_if;
  import cspf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_value;
  logic [COUNT_W-1:0] pixels_written;

  modport source (output valid, pixel_value, pixels_written, input ready);
  modport sink   (input valid, pixel_value, pixels_written, output ready);
endinterface

### rtl/clipped_span_fill_engine_top.sv
// clipped span fill engine: rgb565 frame buffer with clear, span, rectangle and read commands
//
// in_ch carries one command per transfer (valid/ready); out_ch returns exactly one
// result per command: the pixel read by a read command and the number of pixels
// the command wrote. configuration goes through the apb port; the user must write it only
// while no command is in flight, as the block itself does not enforce this.
// one command is worked on at a time. each command passes the edge, clamp and base
// states; a clear, span or rectangle then writes its pixels, a read reads the frame
// buffer, and every command ends in the done state, which registers its result. the
// frame buffer memory takes one pixel write per cycle, which sets the fill rate.
// after reset the block sweeps the frame buffer to zero, one pixel a cycle, with
// in_ch.ready low; configuration writes are taken meanwhile.
// a finished result waits in an output register, and the next command is accepted
// while it does; the command after that finishes only once out_ch has taken it.
module clipped_span_fill_engine_top #(
  parameter int WIDTH  = cspf_pkg::WIDTH_DEF,
  parameter int HEIGHT = cspf_pkg::HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cspf_in_if.sink                       in_ch,
  cspf_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cspf_pkg::PADDR_W-1:0]  paddr,
  input  logic [cspf_pkg::PDATA_W-1:0]  pwdata,
  output logic [cspf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import cspf_pkg::*;

  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t               cfg;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [COLOR_W-1:0] mem_rdata;

  cspf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cspf_ctrl #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  cspf_fbmem #(
    .DEPTH (DEPTH)
  ) u_fbmem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  a_no_accept_while_writing: assert property (
    @(posedge clk) disable iff (!rst_n) mem_we |-> !in_ch.ready
  ) else $error("command accepted while the frame buffer is being written");

  a_one_command_at_a_time: assert property (
    @(posedge clk) disable iff (!rst_n) (in_ch.valid && in_ch.ready) |=> !in_ch.ready
  ) else $error("second command accepted before the first finished");

  a_result_from_busy: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(out_ch.valid) |-> !$past(in_ch.ready)
  ) else $error("result appeared without a command being worked on");

endmodule

### rtl/cspf_regs.sv
// configuration register file behind the apb port
module cspf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cspf_pkg::PADDR_W-1:0]  paddr,
  input  logic [cspf_pkg::PDATA_W-1:0]  pwdata,
  output logic [cspf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output cspf_pkg::cfg_t                cfg
);
  import cspf_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness  <= BRIGHTNESS_RST;
      cfg_r.clip_left   <= CLIP_LEFT_RST;
      cfg_r.clip_top    <= CLIP_TOP_RST;
      cfg_r.clip_right  <= CLIP_RIGHT_RST;
      cfg_r.clip_bottom <= CLIP_BOTTOM_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_BRIGHTNESS:  cfg_r.brightness  <= pwdata[7:0];
        REG_CLIP_LEFT:   cfg_r.clip_left   <= pwdata[8:0];
        REG_CLIP_TOP:    cfg_r.clip_top    <= pwdata[7:0];
        REG_CLIP_RIGHT:  cfg_r.clip_right  <= pwdata[8:0];
        REG_CLIP_BOTTOM: cfg_r.clip_bottom <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BRIGHTNESS:  prdata = PDATA_W'(cfg_r.brightness);
      REG_CLIP_LEFT:   prdata = PDATA_W'(cfg_r.clip_left);
      REG_CLIP_TOP:    prdata = PDATA_W'(cfg_r.clip_top);
      REG_CLIP_RIGHT:  prdata = PDATA_W'(cfg_r.clip_right);
      REG_CLIP_BOTTOM: prdata = PDATA_W'(cfg_r.clip_bottom);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/cspf_fbmem.sv
// frame buffer memory, one write and one registered read per cycle at a shared address
module cspf_fbmem #(
  parameter  int DEPTH = cspf_pkg::WIDTH_DEF * cspf_pkg::HEIGHT_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 addr,
  input  logic [cspf_pkg::COLOR_W-1:0]  wdata,
  output logic [cspf_pkg::COLOR_W-1:0]  rdata
);
  import cspf_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

### rtl/cspf_ctrl.sv
// command sequencer: bounds, colour scaling, pixel walk and result register
module cspf_ctrl #(
  parameter  int WIDTH  = cspf_pkg::WIDTH_DEF,
  parameter  int HEIGHT = cspf_pkg::HEIGHT_DEF,
  localparam int DEPTH  = WIDTH * HEIGHT,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cspf_pkg::cfg_t                cfg,
  cspf_in_if.sink                       in_ch,
  cspf_out_if.source                    out_ch,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_addr,
  output logic [cspf_pkg::COLOR_W-1:0]  mem_wdata,
  input  logic [cspf_pkg::COLOR_W-1:0]  mem_rdata
);
  import cspf_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int RW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

  localparam logic signed [17:0] WID_S  = 18'(WIDTH);
  localparam logic signed [17:0] HGT_S  = 18'(HEIGHT);
  localparam logic        [13:0] WID_U  = 14'(WIDTH);
  localparam logic        [13:0] HGT_U  = 14'(HEIGHT);
  localparam logic     [AW-1:0]  WID_A  = AW'(WIDTH);
  localparam logic     [AW-1:0]  LAST_A = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EDGE, S_CLAMP, S_BASE, S_FILL, S_RD, S_RWAIT, S_DONE
  } state_t;

  function automatic logic [5:0] div255(input logic [13:0] v);
    logic [14:0] t;
    t = 15'(v) + 15'(v[13:8]) + 15'd1;
    return t[13:8];
  endfunction

  state_t             state_r;
  logic [AW-1:0]      clr_addr_r;

  cmd_t               cmd_r;
  logic [15:0]        x_r, xe_r, y_r, w_r, h_r, color_r;

  logic signed [17:0] bs_r, yl_r, redge_r, bedge_r;
  logic               hpos_r;
  logic [12:0]        pr_r, pb_r;
  logic [13:0]        pg_r;
  logic               byp_r;
  logic [15:0]        dim_r;

  logic signed [17:0] lo_r, hi_r, first_r, last_r;
  logic               rd_ok_r;

  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [AW-1:0]      row_base_r;

  logic [COUNT_W-1:0] cnt_r;
  logic [COLOR_W-1:0] pix_r;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_pix_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic signed [17:0] x_ext, xe_ext, y_ext, w_ext, h_ext;
  logic signed [17:0] left_s, top_s, mn, mx;
  logic [15:0]        sw;
  logic [5:0]         red_s, grn_s, blu_s;
  logic [15:0]        scaled;
  logic               empty;

  assign x_ext  = {{2{x_r[15]}}, x_r};
  assign xe_ext = {{2{xe_r[15]}}, xe_r};
  assign y_ext  = {{2{y_r[15]}}, y_r};
  assign w_ext  = {{2{w_r[15]}}, w_r};
  assign h_ext  = {{2{h_r[15]}}, h_r};
  assign left_s = 18'(cfg.clip_left);
  assign top_s  = 18'(cfg.clip_top);
  assign mn     = (x_ext < bs_r) ? x_ext : bs_r;
  assign mx     = (x_ext < bs_r) ? bs_r : x_ext;
  assign sw     = {color_r[7:0], color_r[15:8]};
  assign red_s  = div255(14'(pr_r));
  assign grn_s  = div255(pg_r);
  assign blu_s  = div255(14'(pb_r));
  assign scaled = {red_s[4:0], grn_s, blu_s[4:0]};
  assign empty  = (lo_r > hi_r) || (first_r > last_r) || !hpos_r;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pixel_value    = out_pix_r;
  assign out_ch.pixels_written = out_cnt_r;

  always_comb begin
    mem_we    = (state_r == S_CLR) || (state_r == S_FILL);
    mem_wdata = (state_r == S_CLR) ? '0 : dim_r;
    mem_addr  = (state_r == S_CLR) ? clr_addr_r : row_base_r + AW'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_A) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.cmd;
            x_r     <= in_ch.x;
            xe_r    <= in_ch.x_end;
            y_r     <= in_ch.y;
            w_r     <= in_ch.width;
            h_r     <= in_ch.height;
            color_r <= in_ch.color;
            cnt_r   <= '0;
            pix_r   <= '0;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          bs_r    <= (cmd_r == CMD_RECT) ? x_ext + w_ext - 18'sd1 : xe_ext;
          yl_r    <= (cmd_r == CMD_RECT) ? y_ext + h_ext - 18'sd1 : y_ext;
          redge_r <= ((14'(cfg.clip_right) > WID_U) ? WID_S : 18'(cfg.clip_right)) - 18'sd1;
          bedge_r <= ((14'(cfg.clip_bottom) > HGT_U) ? HGT_S : 18'(cfg.clip_bottom)) - 18'sd1;
          hpos_r  <= (cmd_r != CMD_RECT) || (!h_r[15] && (h_r != '0));
          pr_r    <= 13'(sw[15:11]) * 13'(cfg.brightness);
          pg_r    <= 14'(sw[10:5]) * 14'(cfg.brightness);
          pb_r    <= 13'(sw[4:0]) * 13'(cfg.brightness);
          byp_r   <= (cfg.brightness == 8'd255);
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          dim_r <= byp_r ? color_r : {scaled[7:0], scaled[15:8]};
          case (cmd_r)
            CMD_CLEAR: begin
              lo_r    <= '0;
              hi_r    <= WID_S - 18'sd1;
              first_r <= '0;
              last_r  <= HGT_S - 18'sd1;
            end
            CMD_READ: begin
              lo_r    <= x_ext;
              first_r <= y_ext;
              rd_ok_r <= !x_ext[17] && (x_ext < WID_S) && !y_ext[17] && (y_ext < HGT_S);
            end
            default: begin
              lo_r    <= (mn < left_s) ? left_s : mn;
              hi_r    <= (mx > redge_r) ? redge_r : mx;
              first_r <= (y_ext < top_s) ? top_s : y_ext;
              last_r  <= (yl_r > bedge_r) ? bedge_r : yl_r;
            end
          endcase
          state_r <= S_BASE;
        end
        S_BASE: begin
          row_r      <= first_r[RW-1:0];
          col_r      <= lo_r[CW-1:0];
          row_base_r <= AW'(first_r[RW-1:0]) * WID_A;
          if (cmd_r == CMD_READ) begin
            state_r <= S_RD;
          end else if (empty) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          cnt_r <= cnt_r + COUNT_W'(1);
          if (col_r == hi_r[CW-1:0]) begin
            col_r <= lo_r[CW-1:0];
            if (row_r == last_r[RW-1:0]) begin
              state_r <= S_DONE;
            end else begin
              row_r      <= row_r + RW'(1);
              row_base_r <= row_base_r + WID_A;
            end
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        S_RD: begin
          state_r <= S_RWAIT;
        end
        S_RWAIT: begin
          pix_r   <= rd_ok_r ? mem_rdata : '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_pix_r   <= pix_r;
            out_cnt_r   <= cnt_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
